// ----- src/mbps_pkg.sv -----
// Shared types and constants for the metaball pixel shader.
// No dependencies; every other file in src imports this package.
`default_nettype none

package mbps_pkg;

  localparam int COORD_W  = 12;  // ball centre, signed
  localparam int RADIUS_W = 8;   // ball radius, unsigned
  localparam int PIX_W    = 10;  // pixel column / row
  localparam int DELTA_W  = 13;  // pixel minus centre, signed
  localparam int SQ_W     = 24;  // one squared delta
  localparam int DIST_W   = 25;  // squared distance
  localparam int RSQ_W    = 16;  // radius squared
  localparam int TERM_W   = 41;  // radius squared times distance
  localparam int S_W      = 42;  // sum of both terms
  localparam int P_W      = 50;  // product of both distances
  localparam int CMP_W    = 54;  // scaled terms in the threshold compares
  localparam int ADDR_W   = 20;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 12;

  localparam int ROW_PITCH_DEFAULT = 320;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = 8'd32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BALL0_X      = 3'd0,
    REG_BALL0_Y      = 3'd1,
    REG_BALL0_RADIUS = 3'd2,
    REG_BALL1_X      = 3'd3,
    REG_BALL1_Y      = 3'd4,
    REG_BALL1_RADIUS = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CLASS_BG    = 2'd0,
    CLASS_GREEN = 2'd1,
    CLASS_WHITE = 2'd2,
    CLASS_BLACK = 2'd3
  } colour_t;

  // load enables of the first three pipeline stages
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

endpackage

`default_nettype wire

// ----- src/mbps_dist.sv -----
// Squared distance from a pixel to one ball centre, three register stages.
// Depends on mbps_pkg; the top level instantiates one per ball.
`default_nettype none

module mbps_dist
  import mbps_pkg::*;
(
  input  wire logic                       clk,
  input  wire stage_en_t                  en,
  input  wire logic        [PIX_W-1:0]    pixel_x,
  input  wire logic        [PIX_W-1:0]    pixel_y,
  input  wire logic signed [COORD_W-1:0]  centre_x,
  input  wire logic signed [COORD_W-1:0]  centre_y,
  output logic             [DIST_W-1:0]   dist_sq
);

  logic signed [DELTA_W-1:0]   dx_next, dy_next;
  logic signed [DELTA_W-1:0]   dx, dy;
  logic signed [2*DELTA_W-1:0] dx_prod, dy_prod;
  logic        [SQ_W-1:0]      dx_sq, dy_sq;

  always_comb begin
    dx_next = $signed(DELTA_W'(pixel_x)) - DELTA_W'(centre_x);
    dy_next = $signed(DELTA_W'(pixel_y)) - DELTA_W'(centre_y);
    dx_prod = dx * dx;
    dy_prod = dy * dy;
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      dx <= dx_next;
      dy <= dy_next;
    end
    if (en.s2) begin
      dx_sq <= dx_prod[SQ_W-1:0];
      dy_sq <= dy_prod[SQ_W-1:0];
    end
    if (en.s3) begin
      dist_sq <= DIST_W'(dx_sq) + DIST_W'(dy_sq);
    end
  end

endmodule

`default_nettype wire

// ----- src/metaball_pixel_shader.sv -----
// Metaball pixel shader top level: config registers, field pipeline, address.
// Depends on mbps_pkg and mbps_dist.
`default_nettype none

// Two-ball metaball shader, one pixel per item.
// Input channel: pixel_x, pixel_y with in_valid / in_stall. Output channel:
// colour_class (0 background, 1 green, 2 white, 3 black) and pixel_address
// (pixel_y * ROW_PITCH + pixel_x, wrapped to 20 bits) with out_valid /
// out_stall. Config channel: cfg_valid / cfg_ready with cfg_index and
// cfg_data; cfg_ready is always high, indexes past the ball registers drop.
// Write config only while no item is in flight.
// Throughput is one item per cycle while the output is not stalled, through
// the seven-stage pipeline (subtract, square, add, multiply, sum, scale,
// compare); an accepted item passes the stages in that order.
// When the receiver stalls, the result holds in the output stage and
// upstream stages keep filling until every stage is occupied; only then is
// in_stall raised. Empty stages close up, so no bubble stalls the input.
// Reset clears all stage valid bits and returns the balls to centre 0,
// radius 32.
module metaball_pixel_shader
  import mbps_pkg::*;
#(
  parameter int ROW_PITCH = ROW_PITCH_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [PIX_W-1:0]      pixel_x,
  input  wire logic [PIX_W-1:0]      pixel_y,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [1:0]                 colour_class,
  output logic [ADDR_W-1:0]          pixel_address,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NUM_STAGES = 7;
  localparam int PITCH_W    = $clog2(ROW_PITCH + 1);
  localparam int PROD_W     = PIX_W + PITCH_W;

  // ---------------- configuration registers ----------------
  logic signed [COORD_W-1:0] ball0_x, ball0_y, ball1_x, ball1_y;
  logic        [RADIUS_W-1:0] ball0_radius, ball1_radius;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ball0_x      <= '0;
      ball0_y      <= '0;
      ball0_radius <= RADIUS_RESET;
      ball1_x      <= '0;
      ball1_y      <= '0;
      ball1_radius <= RADIUS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_BALL0_X:      ball0_x      <= $signed(cfg_data);
        REG_BALL0_Y:      ball0_y      <= $signed(cfg_data);
        REG_BALL0_RADIUS: ball0_radius <= cfg_data[RADIUS_W-1:0];
        REG_BALL1_X:      ball1_x      <= $signed(cfg_data);
        REG_BALL1_Y:      ball1_y      <= $signed(cfg_data);
        REG_BALL1_RADIUS: ball1_radius <= cfg_data[RADIUS_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage control ----------------
  logic [NUM_STAGES:1] v;
  logic [NUM_STAGES:1] ready;
  logic [NUM_STAGES:0] v_up;

  always_comb begin
    v_up = {v, in_valid};
    ready[NUM_STAGES] = !v[NUM_STAGES] || !out_stall;
    for (int k = NUM_STAGES - 1; k >= 1; k--) begin
      ready[k] = !v[k] || ready[k+1];
    end
  end

  assign in_stall = !ready[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      for (int k = 1; k <= NUM_STAGES; k++) begin
        if (ready[k]) begin
          v[k] <= v_up[k-1];
        end
      end
    end
  end

  stage_en_t dist_en;
  assign dist_en = '{s1: ready[1], s2: ready[2], s3: ready[3]};

  // ---------------- distances, stages 1 to 3 ----------------
  logic [DIST_W-1:0] d0, d1;

  mbps_dist u_dist0 (
    .clk      (clk),
    .en       (dist_en),
    .pixel_x  (pixel_x),
    .pixel_y  (pixel_y),
    .centre_x (ball0_x),
    .centre_y (ball0_y),
    .dist_sq  (d0)
  );

  mbps_dist u_dist1 (
    .clk      (clk),
    .en       (dist_en),
    .pixel_x  (pixel_x),
    .pixel_y  (pixel_y),
    .centre_x (ball1_x),
    .centre_y (ball1_y),
    .dist_sq  (d1)
  );

  // ---------------- field pipeline, stages 3 to 7 ----------------
  logic [RSQ_W-1:0]  r0sq, r1sq;
  logic              zero4, zero5, zero6, zero7;
  logic [TERM_W-1:0] term0, term1;
  logic [P_W-1:0]    p4, p5, p6;
  logic [S_W-1:0]    s5, s6;
  logic [CMP_W-1:0]  s20, p13, s5x;
  colour_t           cls_next, cls7;

  // stage 4 products use d0/d1 from stage 3
  always_ff @(posedge clk) begin
    if (ready[3]) begin
      r0sq <= RSQ_W'(ball0_radius) * RSQ_W'(ball0_radius);
      r1sq <= RSQ_W'(ball1_radius) * RSQ_W'(ball1_radius);
    end
    if (ready[4]) begin
      zero4 <= (d0 == '0) || (d1 == '0);
      term0 <= TERM_W'(r0sq) * TERM_W'(d1);
      term1 <= TERM_W'(r1sq) * TERM_W'(d0);
      p4    <= P_W'(d0) * P_W'(d1);
    end
    if (ready[5]) begin
      zero5 <= zero4;
      s5    <= S_W'(term0) + S_W'(term1);
      p5    <= p4;
    end
    if (ready[6]) begin
      zero6 <= zero5;
      s6    <= s5;
      p6    <= p5;
      s20   <= (CMP_W'(s5) << 4) + (CMP_W'(s5) << 2);
      p13   <= (CMP_W'(p5) << 3) + (CMP_W'(p5) << 2) + CMP_W'(p5);
      s5x   <= (CMP_W'(s5) << 2) + CMP_W'(s5);
    end
    if (ready[7]) begin
      zero7 <= zero6;
      cls7  <= cls_next;
    end
  end

  // strict compares: a sum on a threshold takes the lower class
  always_comb begin
    if (zero6 || (s20 > p13)) begin
      cls_next = CLASS_BLACK;
    end else if ((CMP_W'(s6) << 1) > CMP_W'(p6)) begin
      cls_next = CLASS_WHITE;
    end else if (s5x > (CMP_W'(p6) << 1)) begin
      cls_next = CLASS_GREEN;
    end else begin
      cls_next = CLASS_BG;
    end
  end

  // ---------------- frame buffer address ----------------
  logic [PROD_W-1:0] addr_prod;
  logic [PIX_W-1:0]  px1;
  logic [ADDR_W-1:0] addr [2:NUM_STAGES];

  always_ff @(posedge clk) begin
    if (ready[1]) begin
      addr_prod <= PROD_W'(pixel_y) * PROD_W'(ROW_PITCH);
      px1       <= pixel_x;
    end
    if (ready[2]) begin
      addr[2] <= ADDR_W'(addr_prod) + ADDR_W'(px1);
    end
    for (int k = 3; k <= NUM_STAGES; k++) begin
      if (ready[k]) begin
        addr[k] <= addr[k-1];
      end
    end
  end

  assign out_valid     = v[NUM_STAGES];
  assign colour_class  = cls7;
  assign pixel_address = addr[NUM_STAGES];

  // ---------------- assertions ----------------
  // input backs up only when every stage holds an item
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> ((&v) && out_stall))
    else $error("input stalled while the pipeline has room");

  // a pixel on a ball centre always leaves as black
  a_zero_black: assert property (@(posedge clk) disable iff (rst)
    (out_valid && zero7) |-> (colour_class == CLASS_BLACK))
    else $error("zero distance did not give the black class");

  // thresholds are ordered: above 0.65 implies above 0.5
  a_thresh_order: assert property (@(posedge clk) disable iff (rst)
    (v[6] && !zero6 && (s20 > p13)) |-> ((CMP_W'(s6) << 1) > CMP_W'(p6)))
    else $error("threshold compares out of order");

  a_reset_empty: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !out_valid)
    else $error("output valid right after reset");

endmodule

`default_nettype wire

// ----- verif/tb_metaball_pixel_shader.sv -----
// Testbench for metaball_pixel_shader: drives pixels, checks colour class and address.
// Depends on mbps_pkg and the shader RTL; self-checking through its own predictor.
module tb_metaball_pixel_shader;
  import mbps_pkg::*;

  localparam int ROW_PITCH     = ROW_PITCH_DEFAULT;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS   = 107;
  localparam int DRAIN_CYCLES  = 20;
  localparam int CYCLE_LIMIT   = 400000;

  // indexes past the ball registers; the block drops writes to them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [PIX_W-1:0] x;
    logic [PIX_W-1:0] y;
  } pixel_t;

  typedef struct {
    colour_t           cls;
    logic [ADDR_W-1:0] addr;
  } shade_t;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [PIX_W-1:0]      pixel_x = '0;
  logic [PIX_W-1:0]      pixel_y = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [1:0]            colour_class;
  logic [ADDR_W-1:0]     pixel_address;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the ball registers
  logic signed [COORD_W-1:0] ball_x [2];
  logic signed [COORD_W-1:0] ball_y [2];
  logic [RADIUS_W-1:0]       ball_r [2];

  pixel_t pixel_q [$];
  shade_t shade_q [$];
  int     in_gap = 0;
  int     out_gap = 0;
  int     in_gap_odds = 0;
  int     out_gap_odds = 0;
  int     errors = 0;
  int     cycles = 0;

  metaball_pixel_shader #(
    .ROW_PITCH(ROW_PITCH)
  ) u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .pixel_x      (pixel_x),
    .pixel_y      (pixel_y),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .colour_class (colour_class),
    .pixel_address(pixel_address),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Field sum against 0.65, 0.5 and 0.4 by exact cross-multiplication.
  function automatic shade_t shade_pixel(input logic [PIX_W-1:0] px,
                                         input logic [PIX_W-1:0] py);
    longint          dx;
    longint          dy;
    longint unsigned dsq [2];
    longint unsigned rsq [2];
    longint unsigned field_num;
    longint unsigned field_den;
    shade_t          res;
    for (int b = 0; b < 2; b++) begin
      dx = longint'(px) - longint'(ball_x[b]);
      dy = longint'(py) - longint'(ball_y[b]);
      dsq[b] = dx * dx + dy * dy;
      rsq[b] = longint'(ball_r[b]) * longint'(ball_r[b]);
    end
    field_num = rsq[0] * dsq[1] + rsq[1] * dsq[0];
    field_den = dsq[0] * dsq[1];
    if (dsq[0] == 0 || dsq[1] == 0)
      res.cls = CLASS_BLACK;
    else if (20 * field_num > 13 * field_den)
      res.cls = CLASS_BLACK;
    else if (2 * field_num > field_den)
      res.cls = CLASS_WHITE;
    else if (5 * field_num > 2 * field_den)
      res.cls = CLASS_GREEN;
    else
      res.cls = CLASS_BG;
    res.addr = ADDR_W'(longint'(py) * ROW_PITCH + longint'(px));
    return res;
  endfunction

  function automatic logic [PIX_W-1:0] clamp_pix(input int v);
    if (v < 0) return '0;
    if (v > (1 << PIX_W) - 1) return '1;
    return PIX_W'(v);
  endfunction

  // Leaves cfg_valid high; the caller drops it after the last write.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      REG_BALL0_X:      ball_x[0] = data;
      REG_BALL0_Y:      ball_y[0] = data;
      REG_BALL0_RADIUS: ball_r[0] = data[RADIUS_W-1:0];
      REG_BALL1_X:      ball_x[1] = data;
      REG_BALL1_Y:      ball_y[1] = data;
      REG_BALL1_RADIUS: ball_r[1] = data[RADIUS_W-1:0];
      default:          ;
    endcase
  endtask

  task automatic place_balls(input logic [CFG_DATA_W-1:0] x0, y0, r0,
                             input logic [CFG_DATA_W-1:0] x1, y1, r1);
    write_reg(REG_BALL0_X, x0);
    write_reg(REG_BALL0_Y, y0);
    write_reg(REG_BALL0_RADIUS, r0);
    write_reg(REG_BALL1_X, x1);
    write_reg(REG_BALL1_Y, y1);
    write_reg(REG_BALL1_RADIUS, r1);
    if ($urandom_range(1, 0))
      write_reg($urandom_range(1, 0) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic add_pixel(input int x, input int y);
    pixel_q.push_back('{x: clamp_pix(x), y: clamp_pix(y)});
  endtask

  // Mostly pixels around a ball, some on a centre, the rest anywhere.
  task automatic add_random_pixels(input int count);
    int pick;
    int b;
    int span;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(9, 0);
      b = $urandom_range(1, 0);
      span = 2 * int'(ball_r[b]) + 4;
      if (pick == 0)
        add_pixel(ball_x[b], ball_y[b]);
      else if (pick < 7)
        add_pixel(int'(ball_x[b]) + int'($urandom_range(2 * span, 0)) - span,
                  int'(ball_y[b]) + int'($urandom_range(2 * span, 0)) - span);
      else
        add_pixel($urandom_range(1023, 0), $urandom_range(1023, 0));
    end
  endtask

  // Check between edges so the driver and monitor have settled, then
  // return on a rising edge.
  task automatic wait_idle();
    @(negedge clk);
    while (pixel_q.size() != 0 || shade_q.size() != 0 || in_valid) @(negedge clk);
    @(posedge clk);
  endtask

  function automatic logic [CFG_DATA_W-1:0] rand_centre();
    if ($urandom_range(9, 0) < 7) return CFG_DATA_W'($urandom_range(1023, 0));
    return CFG_DATA_W'($urandom);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] rand_radius();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return CFG_DATA_W'(8'hff);
      2:       return CFG_DATA_W'($urandom_range(16, 1));
      default: return CFG_DATA_W'($urandom);
    endcase
  endfunction

  initial begin
    for (int b = 0; b < 2; b++) begin
      ball_x[b] = '0;
      ball_y[b] = '0;
      ball_r[b] = RADIUS_RESET;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    in_gap_odds = 2;
    out_gap_odds = 2;
    // reset values: both balls on the origin
    add_pixel(0, 0);
    add_pixel(1023, 1023);
    add_pixel(1023, 0);
    add_pixel(0, 1023);
    add_pixel(20, 20);

    // ball 1 has zero radius; sums land exactly on 0.65 and 0.5
    wait_idle();
    place_balls(12'd100, 12'd100, 12'd13, 12'h800, 12'h800, 12'd0);
    add_pixel(100, 100);
    add_pixel(116, 101);
    add_pixel(116, 102);
    add_pixel(113, 113);
    add_pixel(113, 112);

    // pixel on the centre of a zero-radius ball; sums exactly on 0.4 and 0.5
    wait_idle();
    place_balls(12'd0, 12'd1023, 12'd0, 12'd500, 12'd600, 12'd10);
    add_pixel(0, 1023);
    add_pixel(500, 600);
    add_pixel(515, 605);
    add_pixel(510, 610);
    add_pixel(514, 605);

    // shared centre, largest radius and radius 1
    wait_idle();
    place_balls(12'd512, 12'd512, 12'hfff, 12'd512, 12'd512, 12'd1);
    add_pixel(512, 512);
    add_pixel(512, 0);
    add_pixel(0, 0);
    add_pixel(1023, 1023);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      wait_idle();
      case (ph % 4)
        0:       begin in_gap_odds = 3; out_gap_odds = 3; end
        1:       begin in_gap_odds = 0; out_gap_odds = 2; end
        2:       begin in_gap_odds = 2; out_gap_odds = 0; end
        default: begin in_gap_odds = 0; out_gap_odds = 0; end
      endcase
      if (ph == RANDOM_PHASES - 1) begin
        in_gap_odds = 0;
        out_gap_odds = 0;
      end
      if (ph == 0)
        place_balls(12'h800, 12'h800, 12'hfff, 12'h7ff, 12'h7ff, 12'h0ff);
      else if (ph == 1)
        place_balls(12'h7ff, 12'h7ff, 12'h000, 12'h800, 12'h800, 12'hf00);
      else
        place_balls(rand_centre(), rand_centre(), rand_radius(),
                    rand_centre(), rand_centre(), rand_radius());
      add_random_pixels(PHASE_ITEMS);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Pixel driver: predict on accept, hold while stalled.
  always @(posedge clk) begin
    pixel_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && !in_stall)
        shade_q.push_back(shade_pixel(pixel_x, pixel_y));
      if (!in_valid || !in_stall) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0 && in_gap_odds > 0 &&
                     $urandom_range(in_gap_odds - 1, 0) == 0) begin
          in_gap = $urandom_range(7, 0);
          in_valid <= 1'b0;
        end else if (pixel_q.size() > 0) begin
          nxt = pixel_q.pop_front();
          in_valid <= 1'b1;
          pixel_x  <= nxt.x;
          pixel_y  <= nxt.y;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and output stall bursts.
  always @(posedge clk) begin
    shade_t want;
    if (rst) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (shade_q.size() == 0) begin
          $error("unexpected item: colour_class %0d, pixel_address %0d",
                 colour_class, pixel_address);
          errors++;
        end else begin
          want = shade_q.pop_front();
          if (colour_class !== want.cls) begin
            $error("colour_class: expected %0d, got %0d", want.cls, colour_class);
            errors++;
          end
          if (pixel_address !== want.addr) begin
            $error("pixel_address: expected %0d, got %0d", want.addr, pixel_address);
            errors++;
          end
        end
      end
      if (out_gap > 0) begin
        out_gap--;
        out_stall <= 1'b1;
      end else if (out_gap_odds > 0 && $urandom_range(out_gap_odds - 1, 0) == 0) begin
        out_gap = $urandom_range(7, 0);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

endmodule
